### rtl/tournament_branch_predictor_defines.svh
// assertion macros used by the checker file
`ifndef TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TBP_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define TBP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### rtl/tbp_pkg.sv
package tbp_pkg;

   // fixed field widths
   localparam int ADDR_WIDTH = 32;
   localparam int WORD_WIDTH = ADDR_WIDTH - 2;
   localparam int CTR_WIDTH  = 2;

   // default table geometry
   localparam int GSHARE_DEPTH_DEF  = 8192;
   localparam int BIMODAL_DEPTH_DEF = 4096;
   localparam int CHOOSER_DEPTH_DEF = 4096;
   localparam int HISTORY_BITS_DEF  = 13;

   // counter codes
   localparam logic [CTR_WIDTH-1:0] CTR_RESET = 2'b01;
   localparam logic [CTR_WIDTH-1:0] CTR_MAX   = 2'b11;
   localparam logic [CTR_WIDTH-1:0] CTR_MIN   = 2'b00;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // saturating step of a 2-bit counter
   function automatic logic [CTR_WIDTH-1:0] step_toward(input logic [CTR_WIDTH-1:0] c,
                                                       input logic up);
      logic [CTR_WIDTH-1:0] r;
      if (up) begin
         r = (c == CTR_MAX) ? CTR_MAX : c + 2'b01;
      end else begin
         r = (c == CTR_MIN) ? CTR_MIN : c - 2'b01;
      end
      return r;
   endfunction

endpackage

### rtl/tbp_if.sv
// branch transfer channel
interface tbp_req_if;
   logic                            valid;
   logic                            ready;
   logic [tbp_pkg::ADDR_WIDTH-1:0]  branch_address;
   logic                            taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

// prediction transfer channel
interface tbp_rsp_if;
   logic valid;
   logic ready;
   logic predicted_taken;
   logic mispredicted;

   modport source (output valid, output predicted_taken, output mispredicted, input ready);
   modport sink   (input valid, input predicted_taken, input mispredicted, output ready);
endinterface

### rtl/tbp_ctr_ram.sv
// counter memory, one write port, one registered read port
module tbp_ctr_ram #(
   parameter int DEPTH = tbp_pkg::BIMODAL_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [tbp_pkg::CTR_WIDTH-1:0] rd_data,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [tbp_pkg::CTR_WIDTH-1:0] wr_data
);

   logic [tbp_pkg::CTR_WIDTH-1:0] mem [DEPTH];
   logic [tbp_pkg::CTR_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tournament_branch_predictor.sv
// Tournament branch predictor with bimodal and gshare components and a chooser table.
// Each transfer on req_chan is one resolved branch; one transfer on rsp_chan gives
// the prediction that the tables held before the update and a mispredict flag.
// Each branch is read from the three counter memories, then its counters are combined
// and written back; the next branch is not accepted before that write-back, which
// waits while the output register is full. The result sits in that register, and the
// next branch is accepted while it waits. After reset a clearing pass over addresses
// up to the largest of GSHARE_DEPTH, BIMODAL_DEPTH and CHOOSER_DEPTH sets every
// counter to weakly not taken; no branch is accepted during that pass.
module tournament_branch_predictor #(
   parameter int GSHARE_DEPTH  = tbp_pkg::GSHARE_DEPTH_DEF,
   parameter int BIMODAL_DEPTH = tbp_pkg::BIMODAL_DEPTH_DEF,
   parameter int CHOOSER_DEPTH = tbp_pkg::CHOOSER_DEPTH_DEF,
   parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   tbp_req_if.sink   req_chan,
   tbp_rsp_if.source rsp_chan
);

   localparam int GAW = $clog2(GSHARE_DEPTH);
   localparam int BAW = $clog2(BIMODAL_DEPTH);
   localparam int CAW = $clog2(CHOOSER_DEPTH);
   localparam int MAX_DEPTH = (GSHARE_DEPTH > BIMODAL_DEPTH)
      ? ((GSHARE_DEPTH > CHOOSER_DEPTH) ? GSHARE_DEPTH : CHOOSER_DEPTH)
      : ((BIMODAL_DEPTH > CHOOSER_DEPTH) ? BIMODAL_DEPTH : CHOOSER_DEPTH);
   localparam int XAW = $clog2(MAX_DEPTH);
   localparam logic [GAW-1:0] GMASK = GAW'(GSHARE_DEPTH - 1);
   localparam logic [BAW-1:0] BMASK = BAW'(BIMODAL_DEPTH - 1);
   localparam logic [CAW-1:0] CMASK = CAW'(CHOOSER_DEPTH - 1);
   localparam logic [XAW-1:0] CLR_LAST = XAW'(MAX_DEPTH - 1);
   localparam int WW = tbp_pkg::WORD_WIDTH;
   localparam int CW = tbp_pkg::CTR_WIDTH;

   tbp_pkg::state_type state_ff, state_in;

   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic [XAW-1:0]          clr_addr_ff, clr_addr_in;
   logic                    taken_ff, taken_in;
   logic [GAW-1:0]          gidx_ff, gidx_in;
   logic [BAW-1:0]          bidx_ff, bidx_in;
   logic [CAW-1:0]          cidx_ff, cidx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    pred_ff, pred_in;
   logic                    misp_ff, misp_in;

   logic          req_xfer;
   logic          out_free;
   logic          clr_done;
   logic [WW-1:0] word;
   logic [WW-1:0] hashed;
   logic [HISTORY_BITS:0] hist_shift;

   logic          rd_en;
   logic          wr_en;
   logic [GAW-1:0] g_wr_addr;
   logic [BAW-1:0] b_wr_addr;
   logic [CAW-1:0] c_wr_addr;
   logic [CW-1:0]  g_wr_data, b_wr_data, c_wr_data;
   logic [CW-1:0]  g_rd_data, b_rd_data, c_rd_data;

   logic p_bim, p_gsh, pred, bim_ok, gsh_ok;
   logic [CW-1:0] c_next;

   // handshake and index hashing
   assign req_chan.ready = (state_ff == tbp_pkg::ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign clr_done       = (clr_addr_ff == CLR_LAST);
   assign word   = req_chan.branch_address[tbp_pkg::ADDR_WIDTH-1:2];
   assign hashed = word ^ {{(WW-HISTORY_BITS){1'b0}}, hist_ff};

   // history shifted by one with the outcome in the low bit
   assign hist_shift = {hist_ff, taken_ff};

   // component predictions and chooser update
   assign p_bim  = b_rd_data[1];
   assign p_gsh  = g_rd_data[1];
   assign pred   = c_rd_data[1] ? p_gsh : p_bim;
   assign bim_ok = (p_bim == taken_ff);
   assign gsh_ok = (p_gsh == taken_ff);

   always_comb begin
      if (gsh_ok && !bim_ok) begin
         c_next = tbp_pkg::step_toward(c_rd_data, 1'b1);
      end else if (bim_ok && !gsh_ok) begin
         c_next = tbp_pkg::step_toward(c_rd_data, 1'b0);
      end else begin
         c_next = c_rd_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            if (clr_done) state_in = tbp_pkg::ST_IDLE;
         end
         tbp_pkg::ST_IDLE: begin
            if (req_xfer) state_in = tbp_pkg::ST_LOOKUP;
         end
         tbp_pkg::ST_LOOKUP: begin
            if (out_free) state_in = tbp_pkg::ST_IDLE;
         end
         default: state_in = tbp_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      hist_in      = hist_ff;
      clr_addr_in  = clr_addr_ff;
      taken_in     = taken_ff;
      gidx_in      = gidx_ff;
      bidx_in      = bidx_ff;
      cidx_in      = cidx_ff;
      pred_in      = pred_ff;
      misp_in      = misp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      g_wr_addr    = gidx_ff;
      b_wr_addr    = bidx_ff;
      c_wr_addr    = cidx_ff;
      g_wr_data    = tbp_pkg::step_toward(g_rd_data, taken_ff);
      b_wr_data    = tbp_pkg::step_toward(b_rd_data, taken_ff);
      c_wr_data    = c_next;
      case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            g_wr_addr   = clr_addr_ff[GAW-1:0] & GMASK;
            b_wr_addr   = clr_addr_ff[BAW-1:0] & BMASK;
            c_wr_addr   = clr_addr_ff[CAW-1:0] & CMASK;
            g_wr_data   = tbp_pkg::CTR_RESET;
            b_wr_data   = tbp_pkg::CTR_RESET;
            c_wr_data   = tbp_pkg::CTR_RESET;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         tbp_pkg::ST_IDLE: begin
            if (req_xfer) begin
               rd_en    = 1'b1;
               taken_in = req_chan.taken;
               gidx_in  = hashed[GAW-1:0] & GMASK;
               bidx_in  = word[BAW-1:0] & BMASK;
               cidx_in  = hashed[CAW-1:0] & CMASK;
            end
         end
         tbp_pkg::ST_LOOKUP: begin
            if (out_free) begin
               wr_en        = 1'b1;
               hist_in      = hist_shift[HISTORY_BITS-1:0];
               pred_in      = pred;
               misp_in      = pred != taken_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbp_pkg::ST_CLEAR;
         hist_ff      <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      taken_ff <= taken_in;
      gidx_ff  <= gidx_in;
      bidx_ff  <= bidx_in;
      cidx_ff  <= cidx_in;
      pred_ff  <= pred_in;
      misp_ff  <= misp_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.predicted_taken = pred_ff;
   assign rsp_chan.mispredicted    = misp_ff;

   // counter memories
   tbp_ctr_ram #(.DEPTH(GSHARE_DEPTH)) u_gshare (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (gidx_in),
      .rd_data (g_rd_data),
      .wr_en   (wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data)
   );

   tbp_ctr_ram #(.DEPTH(BIMODAL_DEPTH)) u_bimodal (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (bidx_in),
      .rd_data (b_rd_data),
      .wr_en   (wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data)
   );

   tbp_ctr_ram #(.DEPTH(CHOOSER_DEPTH)) u_chooser (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (cidx_in),
      .rd_data (c_rd_data),
      .wr_en   (wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data)
   );

endmodule

### rtl/tbp_checker.sv
`include "tournament_branch_predictor_defines.svh"

// port-level checks of the predictor
module tbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff, pending_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // branches accepted whose prediction is not yet transferred
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `TBP_ASSERT_IMPLY(a_no_spurious_rsp, clock, reset, rsp_valid, pending_ff != 2'd0, "prediction without a branch")
   `TBP_ASSERT_IMPLY(a_two_in_flight, clock, reset, req_xfer, pending_ff != 2'd2, "more than two branches in flight")
   `TBP_ASSERT_NEXT(a_ready_drops, clock, reset, req_xfer, !req_ready, "branch accepted in back-to-back cycles")
   `TBP_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "prediction withdrawn before transfer")

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
